// ===== sv/quadratic_probe_hash_table_defines.svh =====
// Assertion macros used by the hash table top level.
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define QPH_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define QPH_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qph_pkg.sv =====
// Package with the widths, codes and types of the hash table.
`default_nettype none

package qph_pkg;

	// Field widths of the command and result words.
	localparam int KEY_W    = 31;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int OCC_W    = 5;

	// One memory word holds the valid flag above the key.
	localparam int WORD_W = KEY_W + 1;

	// Default table depth.
	localparam int TABLE_SIZE_DEF = 16;

	// Operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_CHECK
	} state_t;

endpackage

`default_nettype wire

// ===== sv/qph_ram.sv =====
// Generic single-port RAM with a registered read.
`default_nettype none

module qph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a write, or a read that appears in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/qph_home.sv =====
// Reciprocal-multiply pipeline that reduces a key modulo the table size.
`default_nettype none

module qph_home #(
	parameter int TABLE_SIZE = qph_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [qph_pkg::KEY_W-1:0]     key,
	output logic                               done,
	output logic [$clog2(TABLE_SIZE)-1:0]      home
);

	import qph_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	// The key times a rounded-up reciprocal, shifted down, gives the exact quotient.
	localparam int MUL_W = 2 * KEY_W + 1;
	localparam int SHIFT = KEY_W + IDX_W;
	localparam logic [63:0] POW2       = 64'd1 << SHIFT;
	localparam logic [63:0] RECIP_FULL = (POW2 + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
	localparam logic [KEY_W:0]   RECIP   = RECIP_FULL[KEY_W:0];
	localparam logic [IDX_W-1:0] SIZE_LO = IDX_W'(TABLE_SIZE);

	logic [KEY_W-1:0] key_s1;
	logic             vld_s1;
	logic [MUL_W-1:0] prod;
	logic [IDX_W-1:0] quo_s2;
	logic [IDX_W-1:0] klo_s2;
	logic             vld_s2;
	logic [IDX_W-1:0] rem_q;
	logic             done_q;

	// A 31 by 32 bit product of the captured key and the reciprocal.
	assign prod = MUL_W'(key_s1) * MUL_W'(RECIP);

	// Stage valid flags and the completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Key capture, quotient, then the remainder. The remainder is below the size,
	// so only the low index bits of the key and of quotient times size matter.
	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		quo_s2 <= prod[SHIFT +: IDX_W];
		klo_s2 <= key_s1[IDX_W-1:0];
		if (vld_s2) begin
			rem_q <= klo_s2 - quo_s2 * SIZE_LO;
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

`default_nettype wire

// ===== sv/quadratic_probe_hash_table.sv =====
// Top level of the quadratic-probing hash table: controller, memory and count.
//
// An open-addressed table of TABLE_SIZE slots held in one single-port RAM, each word
// a valid flag and a 31-bit key. A command word (mode, key) is taken when start is
// high and busy is low. The home slot, key mod TABLE_SIZE, comes from a short pipeline
// that multiplies the key by a reciprocal of TABLE_SIZE (key capture, quotient, then
// remainder); then one slot of the probe sequence (home + i*i) is examined per cycle
// through the RAM's single port, up to TABLE_SIZE slots. A hit that must change the
// table writes the RAM in the cycle that examines it. The result word is shown for
// exactly one cycle with done high; busy drops in that same cycle, so the next
// command can be taken while the result is shown. An unused mode gives its result in
// the cycle after it is taken. The receiver cannot stall: a result not captured while
// done is high is gone. After reset the block clears the RAM, one slot a cycle, and
// holds busy high until every slot is cleared.
`default_nettype none

`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table #(
	parameter int TABLE_SIZE = qph_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [qph_pkg::MODE_W-1:0]    mode,
	input  wire logic [qph_pkg::KEY_W-1:0]     key,
	output logic                               done,
	output logic [qph_pkg::STATUS_W-1:0]       status,
	output logic [qph_pkg::SLOT_W-1:0]         slot,
	output logic [qph_pkg::OCC_W-1:0]          occupied
);

	import qph_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [IDX_W:0]   SIZE_X   = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  clr_q, clr_d;
	logic              done_q, done_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  off_q, off_d;
	logic [IDX_W-1:0]  d_q, d_d;
	logic [IDX_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  probe_q, probe_d;
	status_t           status_q, status_d;
	logic [IDX_W-1:0]  slot_q, slot_d;

	logic              accept;
	logic              mode_ok;
	logic              home_start;
	logic              home_done;
	logic [IDX_W-1:0]  home;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic [IDX_W:0]    sum_off, sum_d, sum_pr;
	logic [IDX_W-1:0]  off_nx, d_nx, probe_nx;
	logic              rd_valid, rd_match, is_ins, is_del, hit;

	logic [IDX_W+SLOT_W-1:0] slot_ext;
	logic [CNT_W+OCC_W-1:0]  occ_ext;

	// Command acceptance.
	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign mode_ok    = (mode == MODE_INSERT) || (mode == MODE_SEARCH) || (mode == MODE_DELETE);
	assign home_start = accept && mode_ok;

	qph_home #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (home_start),
		.key   (key),
		.done  (home_done),
		.home  (home)
	);

	qph_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Next probe: offset steps by the odd increment, all sums reduced by one subtract.
	always_comb begin
		sum_off  = {1'b0, off_q} + {1'b0, d_q};
		off_nx   = (sum_off >= SIZE_X) ? IDX_W'(sum_off - SIZE_X) : sum_off[IDX_W-1:0];
		sum_d    = {1'b0, d_q} + (IDX_W+1)'(2);
		d_nx     = (sum_d >= SIZE_X) ? IDX_W'(sum_d - SIZE_X) : sum_d[IDX_W-1:0];
		sum_pr   = {1'b0, home} + {1'b0, off_nx};
		probe_nx = (sum_pr >= SIZE_X) ? IDX_W'(sum_pr - SIZE_X) : sum_pr[IDX_W-1:0];
	end

	// Decode of the word read for the current probe.
	assign rd_valid = ram_rdata[KEY_W];
	assign rd_match = rd_valid && (ram_rdata[KEY_W-1:0] == key_q);
	assign is_ins   = (mode_q == MODE_INSERT);
	assign is_del   = (mode_q == MODE_DELETE);
	assign hit      = is_ins ? !rd_valid : rd_match;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state, memory control and result.
	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		done_d    = 1'b0;
		cnt_d     = cnt_q;
		off_d     = off_q;
		d_d       = d_q;
		i_d       = i_q;
		probe_d   = probe_q;
		status_d  = status_q;
		slot_d    = slot_q;
		ram_we    = 1'b0;
		ram_addr  = probe_q;
		ram_wdata = {1'b0, key_q};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + IDX_W'(1);
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (mode_ok) begin
						state_d = S_HOME;
					end else begin
						status_d = ST_MISSING;
						slot_d   = '0;
						done_d   = 1'b1;
					end
				end
			end
			S_HOME: begin
				ram_addr = home;
				if (home_done) begin
					probe_d = home;
					off_d   = '0;
					d_d     = IDX_W'(1);
					i_d     = '0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (hit) begin
					ram_we    = is_ins || is_del;
					ram_wdata = {is_ins, key_q};
					if (is_ins) begin
						cnt_d = cnt_q + CNT_W'(1);
					end else if (is_del) begin
						cnt_d = cnt_q - CNT_W'(1);
					end
					status_d = ST_OK;
					slot_d   = probe_q;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else if (i_q == LAST_IDX) begin
					status_d = is_ins ? ST_FULL : ST_MISSING;
					slot_d   = '0;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ram_addr = probe_nx;
					probe_d  = probe_nx;
					off_d    = off_nx;
					d_d      = d_nx;
					i_d      = i_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Command and probe registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= key;
		end
		off_q    <= off_d;
		d_q      <= d_d;
		i_q      <= i_d;
		probe_q  <= probe_d;
		status_q <= status_d;
		slot_q   <= slot_d;
	end

	// Result word, sized to the port widths.
	assign slot_ext = {{SLOT_W{1'b0}}, slot_q};
	assign occ_ext  = {{OCC_W{1'b0}}, cnt_q};
	assign done     = done_q;
	assign status   = status_q;
	assign slot     = slot_ext[SLOT_W-1:0];
	assign occupied = occ_ext[OCC_W-1:0];

	// Checks on the controller.
	`QPH_CHECK(a_done_idle, done_q, state_q == S_IDLE, "result shown while not idle")
	`QPH_CHECK(a_cnt_range, 1'b1, cnt_q <= CNT_W'(TABLE_SIZE), "occupied count above table size")
	`QPH_CHECK(a_slot_zero, done_q && (status_q != ST_OK), slot_q == '0, "slot nonzero on a miss")
	`QPH_CHECK(a_we_state, ram_we, (state_q == S_CLEAR) || (state_q == S_CHECK), "stray RAM write")
	`QPH_CHECK_NEXT(a_go_home, home_start, state_q == S_HOME, "valid command did not start probing")

endmodule

`default_nettype wire
